### rtl/skset_pkg.sv
// ----------------------------------------------------------------------------
// skset_pkg
// Shared widths, action codes and result status codes for the sorted key set.
// ----------------------------------------------------------------------------
package skset_pkg;

  localparam int KEY_W    = 64;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [COUNT_W-1:0] count_t;

  // request actions (any other code behaves as a lookup)
  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;

  // result status codes
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

### rtl/skset_if.sv
// ----------------------------------------------------------------------------
// skset_in_if / skset_out_if
// Valid/ready channels for requests and results of the sorted key set.
// ----------------------------------------------------------------------------
interface skset_in_if;
  import skset_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  key_t    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface skset_out_if;
  import skset_pkg::*;

  logic    valid;
  logic    ready;
  logic    found;
  status_t status;
  count_t  entry_count;

  modport source (output valid, output found, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input status, input entry_count,
                  output ready);
endinterface

### rtl/skset_store.sv
// ----------------------------------------------------------------------------
// skset_store
// Key storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module skset_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  skset_pkg::key_t          wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output skset_pkg::key_t          rdata
);
  import skset_pkg::*;

  key_t mem [DEPTH];
  key_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sorted_key_set_core.sv
// ----------------------------------------------------------------------------
// sorted_key_set_core
// Ascending duplicate-free set of signed 64-bit keys with lookup, insert and
// remove by binary search over a key store with one write port and one read port.
// ----------------------------------------------------------------------------
// Search: each probe reads the store, then compares the entry with the key;
//   an insert or remove then shifts the entries behind the position one place
//   along, and an insert writes the new key into the opened gap.
// Throughput: one transaction at a time; the next is taken once the result is
//   in the output register.
// Reset: the count and control clear at once; the store is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_set_core #(
  parameter int CAPACITY = 256
) (
  input logic        clk,
  input logic        rst_n,
  skset_in_if.sink   in_ch,
  skset_out_if.source out_ch
);
  import skset_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  action_t           action_r, action_nxt;
  key_t              key_r, key_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  mid_r, mid_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              hit_r, hit_nxt;
  logic              up_r, up_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  status_t           out_status_r, out_status_nxt;
  count_t            out_count_r, out_count_nxt;

  logic [CNT_W-1:0]  mid_c;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  key_t              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  key_t              mem_rdata;

  skset_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // search midpoint and count as seen on the result port
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);
  assign cnt_ext = {{COUNT_W{1'b0}}, count_nxt};

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  // sequencer: search probes, decision, entry shifting, result hand-off
  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    hit_nxt        = hit_r;
    up_nxt         = up_r;
    pend_nxt       = pend_r;
    wr_addr_nxt    = wr_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = mid_c[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          action_nxt = in_ch.action;
          key_nxt    = in_ch.key;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          state_nxt  = S_SRCH;
        end
      end

      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_WAIT;
        end else begin
          pos_nxt   = lo_r;
          hit_nxt   = 1'b0;
          state_nxt = S_DEC;
        end
      end

      S_WAIT: begin
        if (mem_rdata < key_r) begin
          lo_nxt    = mid_r + ONE_CNT;
          state_nxt = S_SRCH;
        end else if (mem_rdata > key_r) begin
          hi_nxt    = mid_r;
          state_nxt = S_SRCH;
        end else begin
          pos_nxt   = mid_r;
          hit_nxt   = 1'b1;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        pend_nxt = 1'b0;
        case (action_r)
          ACT_INSERT: begin
            if (hit_r) begin
              res_status_nxt = ST_PRESENT;
              state_nxt      = S_DONE;
            end else if (count_r >= CAP_CNT) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              res_status_nxt = ST_DONE;
              up_nxt         = 1'b1;
              ptr_nxt        = count_r;
              state_nxt      = S_SHIFT;
            end
          end
          ACT_REMOVE: begin
            if (!hit_r) begin
              res_status_nxt = ST_ABSENT;
              state_nxt      = S_DONE;
            end else begin
              res_status_nxt = ST_DONE;
              up_nxt         = 1'b0;
              ptr_nxt        = pos_r + ONE_CNT;
              state_nxt      = S_SHIFT;
            end
          end
          default: begin
            res_status_nxt = hit_r ? ST_DONE : ST_ABSENT;
            state_nxt      = S_DONE;
          end
        endcase
      end

      S_SHIFT: begin
        // write back the entry read last cycle one place along
        mem_we = pend_r;
        if (up_r) begin
          mem_raddr = ptr_r[ADDR_W-1:0] - ADDR_W'(1);
          if (ptr_r > pos_r) begin
            pend_nxt    = 1'b1;
            wr_addr_nxt = ptr_r[ADDR_W-1:0];
            ptr_nxt     = ptr_r - ONE_CNT;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
          end else begin
            // gap is open: drop the new key in
            mem_we    = 1'b1;
            mem_waddr = pos_r[ADDR_W-1:0];
            mem_wdata = key_r;
            count_nxt = count_r + ONE_CNT;
            state_nxt = S_DONE;
          end
        end else begin
          mem_raddr = ptr_r[ADDR_W-1:0];
          if (ptr_r < count_r) begin
            pend_nxt    = 1'b1;
            wr_addr_nxt = ptr_r[ADDR_W-1:0] - ADDR_W'(1);
            ptr_nxt     = ptr_r + ONE_CNT;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
          end else begin
            count_nxt = count_r - ONE_CNT;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = cnt_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    hit_r        <= hit_nxt;
    up_r         <= up_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef SYNTH
  // count never exceeds the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // a full report only when the store is actually full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (res_status_r == ST_FULL) |-> count_r == CAP_CNT)
    else $error("full status with room left");

  // a pending shift write never lands beyond the slot just past the held entries
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) && pend_r |-> CNT_W'(wr_addr_r) <= count_r)
    else $error("shift write beyond held entries");

  // an accepted transaction always starts a search
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_SRCH)
    else $error("accepted transaction did not start a search");
`endif

endmodule
